FILE: rtl/core/ssie_pkg.sv
// ----------------------------------------------------------------------------
// ssie_pkg
// Shared types and constants of the small stack ISA executor.
// ----------------------------------------------------------------------------
package ssie_pkg;

  localparam int unsigned STACK_DEPTH  = 2048;
  localparam int unsigned MEMORY_WORDS = 2048;
  localparam int unsigned NUM_REGS     = 4;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA_W   = $clog2(STACK_DEPTH);
  localparam int unsigned MA_W   = $clog2(MEMORY_WORDS);
  localparam int unsigned RIDX_W = $clog2(NUM_REGS);
  localparam int unsigned QP_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [RIDX_W-1:0] PC_REG  = RIDX_W'(2);
  localparam logic [31:0]       PC_STEP = 32'd4;

  localparam logic [4:0] OPC_MOVI  = 5'd0;
  localparam logic [4:0] OPC_MOVR  = 5'd1;
  localparam logic [4:0] OPC_NOP2  = 5'd2;
  localparam logic [4:0] OPC_NOP3  = 5'd3;
  localparam logic [4:0] OPC_PUSH  = 5'd4;
  localparam logic [4:0] OPC_ADDI  = 5'd5;
  localparam logic [4:0] OPC_ADDR  = 5'd6;
  localparam logic [4:0] OPC_POP   = 5'd9;
  localparam logic [4:0] OPC_MULI  = 5'd10;
  localparam logic [4:0] OPC_MULR  = 5'd11;
  localparam logic [4:0] OPC_LDR   = 5'd14;
  localparam logic [4:0] OPC_NOP15 = 5'd15;
  localparam logic [4:0] OPC_NOP16 = 5'd16;
  localparam logic [4:0] OPC_NOP17 = 5'd17;
  localparam logic [4:0] OPC_NOP18 = 5'd18;
  localparam logic [4:0] OPC_STR   = 5'd19;
  localparam logic [4:0] OPC_NOP20 = 5'd20;
  localparam logic [4:0] OPC_NOP21 = 5'd21;

  typedef enum logic [3:0] {
    K_MOVI, K_MOVR, K_PUSH, K_ADDI, K_ADDR, K_POP,
    K_MULI, K_MULR, K_LDR, K_STR, K_NOP, K_ILLEGAL
  } opkind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_RANGE     = 3'd3,
    ST_OPCODE    = 3'd4,
    ST_REGISTER  = 3'd5,
    ST_HALTED    = 3'd6
  } status_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic        end_of_program;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] reg0;
    logic [31:0] reg1;
    logic [31:0] reg2;
    logic [31:0] reg3;
    logic        program_done;
  } rsp_t;

  typedef struct packed {
    opkind_e           kind;
    logic              reg_err;
    logic [RIDX_W-1:0] dst;
    logic [RIDX_W-1:0] src;
    logic [23:0]       imm;
    logic              done;
  } dec_t;

endpackage

FILE: rtl/core/ssie_front.sv
// ----------------------------------------------------------------------------
// ssie_front
// Request intake: decodes each instruction and pushes it into the queue.
// ----------------------------------------------------------------------------
module ssie_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ssie_pkg::req_t in_req_i,
  input  logic          clearing_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output ssie_pkg::dec_t q_dec_o
);
  import ssie_pkg::*;

  logic [4:0] opc;
  logic [2:0] d_idx;
  logic [2:0] s_idx;
  logic       uses_d;
  logic       uses_s;
  opkind_e    kind;

  assign opc   = in_req_i.instruction[31:27];
  assign d_idx = in_req_i.instruction[26:24];
  assign s_idx = in_req_i.instruction[23:21];

  always_comb begin
    unique case (opc) inside
      OPC_MOVI:  kind = K_MOVI;
      OPC_MOVR:  kind = K_MOVR;
      OPC_PUSH:  kind = K_PUSH;
      OPC_ADDI:  kind = K_ADDI;
      OPC_ADDR:  kind = K_ADDR;
      OPC_POP:   kind = K_POP;
      OPC_MULI:  kind = K_MULI;
      OPC_MULR:  kind = K_MULR;
      OPC_LDR:   kind = K_LDR;
      OPC_STR:   kind = K_STR;
      OPC_NOP2, OPC_NOP3, OPC_NOP15, OPC_NOP16,
      OPC_NOP17, OPC_NOP18, OPC_NOP20, OPC_NOP21: kind = K_NOP;
      default:   kind = K_ILLEGAL;
    endcase
  end

  always_comb begin
    uses_d = 1'b0;
    uses_s = 1'b0;
    case (kind)
      K_MOVI, K_PUSH, K_ADDI, K_POP, K_MULI: uses_d = 1'b1;
      K_MOVR, K_ADDR, K_MULR, K_LDR, K_STR: begin
        uses_d = 1'b1;
        uses_s = 1'b1;
      end
      default: begin
        uses_d = 1'b0;
        uses_s = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !q_full_i && !clearing_i;
  assign q_push_o   = in_valid_i && in_ready_o;

  assign q_dec_o.kind    = kind;
  assign q_dec_o.reg_err = (uses_d && (d_idx >= 3'(NUM_REGS))) ||
                           (uses_s && (s_idx >= 3'(NUM_REGS)));
  assign q_dec_o.dst     = d_idx[RIDX_W-1:0];
  assign q_dec_o.src     = s_idx[RIDX_W-1:0];
  assign q_dec_o.imm     = in_req_i.instruction[23:0];
  assign q_dec_o.done    = in_req_i.end_of_program;

endmodule

FILE: rtl/core/ssie_queue.sv
// ----------------------------------------------------------------------------
// ssie_queue
// Short queue of decoded requests between intake and execution.
// ----------------------------------------------------------------------------
module ssie_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssie_pkg::dec_t dec_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ssie_pkg::dec_t dec_o
);
  import ssie_pkg::*;

  dec_t            ent_q [QUEUE_DEPTH];
  logic [QP_W-1:0] wptr_q, wptr_d;
  logic [QP_W-1:0] rptr_q, rptr_d;
  logic [QC_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QC_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign dec_o   = ent_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QP_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QP_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= dec_i;
    end
  end

endmodule

FILE: rtl/core/ssie_back.sv
// ----------------------------------------------------------------------------
// ssie_back
// Execution: register file, stack and data memory, with forwarding of
// stack and memory read data into the next request.
// ----------------------------------------------------------------------------
module ssie_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           x_valid_i,
  input  ssie_pkg::dec_t x_dec_i,
  output logic           x_pop_o,
  output logic           clearing_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssie_pkg::rsp_t out_rsp_o
);
  import ssie_pkg::*;

  logic [NUM_REGS-1:0][31:0] arch_q, arch_d;
  logic [NUM_REGS-1:0][31:0] cur, ev, nr;
  logic              pend_q, pend_d;
  logic              pend_mem_q, pend_mem_d;
  logic [RIDX_W-1:0] pend_dst_q, pend_dst_d;
  logic [SP_W-1:0]   sp_q, sp_d, sp_nx;
  logic              halted_q, halted_d;
  logic              clr_q;
  logic [MA_W-1:0]   clr_addr_q;
  logic              w_valid_q;
  status_e           w_status_q;
  logic              w_done_q;

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] stk_rdata_q;
  logic [31:0] dat_mem [MEMORY_WORDS];
  logic [31:0] dat_rdata_q;

  logic        x_adv;
  status_e     status;
  logic [31:0] opd, ops, imm32, add_b, mul_b, sum, prod;
  logic        addr_ok;
  logic        stk_we, stk_re, dat_we, dat_re;
  logic [SA_W-1:0] pop_addr;

  assign x_adv      = x_valid_i && !clr_q && (!w_valid_q || out_ready_i);
  assign x_pop_o    = x_adv;
  assign clearing_o = clr_q;

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      cur[i] = (pend_q && pend_dst_q == RIDX_W'(i)) ?
               (pend_mem_q ? dat_rdata_q : stk_rdata_q) : arch_q[i];
    end
    ev         = cur;
    ev[PC_REG] = cur[PC_REG] + PC_STEP;
  end

  assign opd      = ev[x_dec_i.dst];
  assign ops      = ev[x_dec_i.src];
  assign imm32    = {8'd0, x_dec_i.imm};
  assign add_b    = (x_dec_i.kind == K_ADDI) ? imm32 : ops;
  assign mul_b    = (x_dec_i.kind == K_MULI) ? imm32 : ops;
  assign sum      = opd + add_b;
  assign prod     = opd * mul_b;
  assign addr_ok  = ops < 32'(MEMORY_WORDS);
  assign pop_addr = SA_W'(sp_q - SP_W'(1));

  always_comb begin
    status  = ST_OK;
    nr      = ev;
    sp_nx   = sp_q;
    stk_we  = 1'b0;
    stk_re  = 1'b0;
    dat_we  = 1'b0;
    dat_re  = 1'b0;
    if (halted_q) begin
      status = ST_HALTED;
      nr     = cur;
    end else if (x_dec_i.kind == K_ILLEGAL) begin
      status = ST_OPCODE;
    end else if (x_dec_i.reg_err) begin
      status = ST_REGISTER;
    end else begin
      case (x_dec_i.kind)
        K_MOVI: nr[x_dec_i.dst] = imm32;
        K_MOVR: nr[x_dec_i.dst] = ops;
        K_ADDI, K_ADDR: nr[x_dec_i.dst] = sum;
        K_MULI, K_MULR: nr[x_dec_i.dst] = prod;
        K_PUSH: begin
          if (sp_q >= SP_W'(STACK_DEPTH)) begin
            status = ST_OVERFLOW;
          end else begin
            stk_we = 1'b1;
            sp_nx  = sp_q + SP_W'(1);
          end
        end
        K_POP: begin
          if (sp_q == '0) begin
            status = ST_UNDERFLOW;
          end else begin
            stk_re = 1'b1;
            sp_nx  = sp_q - SP_W'(1);
          end
        end
        K_LDR: begin
          if (!addr_ok) status = ST_RANGE;
          else dat_re = 1'b1;
        end
        K_STR: begin
          if (!addr_ok) status = ST_RANGE;
          else dat_we = 1'b1;
        end
        default: nr = ev;
      endcase
    end
  end

  always_comb begin
    arch_d     = arch_q;
    pend_d     = pend_q;
    pend_mem_d = pend_mem_q;
    pend_dst_d = pend_dst_q;
    sp_d       = sp_q;
    halted_d   = halted_q;
    if (x_adv) begin
      arch_d     = nr;
      pend_d     = stk_re || dat_re;
      pend_mem_d = dat_re;
      pend_dst_d = x_dec_i.dst;
      sp_d       = sp_nx;
      halted_d   = halted_q || (status != ST_OK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arch_q     <= '0;
      pend_q     <= 1'b0;
      pend_mem_q <= 1'b0;
      pend_dst_q <= '0;
      sp_q       <= '0;
      halted_q   <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      w_valid_q  <= 1'b0;
      w_status_q <= ST_OK;
      w_done_q   <= 1'b0;
    end else begin
      arch_q     <= arch_d;
      pend_q     <= pend_d;
      pend_mem_q <= pend_mem_d;
      pend_dst_q <= pend_dst_d;
      sp_q       <= sp_d;
      halted_q   <= halted_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + MA_W'(1);
        if (clr_addr_q == MA_W'(MEMORY_WORDS - 1)) clr_q <= 1'b0;
      end
      if (x_adv) begin
        w_valid_q  <= 1'b1;
        w_status_q <= status;
        w_done_q   <= x_dec_i.done;
      end else if (out_ready_i) begin
        w_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (x_adv && stk_we) begin
      stk_mem[sp_q[SA_W-1:0]] <= opd;
    end
    if (x_adv && stk_re) begin
      stk_rdata_q <= stk_mem[pop_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      dat_mem[clr_addr_q] <= '0;
    end else if (x_adv && dat_we) begin
      dat_mem[ops[MA_W-1:0]] <= opd;
    end
    if (x_adv && dat_re) begin
      dat_rdata_q <= dat_mem[ops[MA_W-1:0]];
    end
  end

  assign out_valid_o            = w_valid_q;
  assign out_rsp_o.status       = w_status_q;
  assign out_rsp_o.reg0         = cur[0];
  assign out_rsp_o.reg1         = cur[1];
  assign out_rsp_o.reg2         = cur[2];
  assign out_rsp_o.reg3         = cur[3];
  assign out_rsp_o.program_done = w_done_q;

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !x_pop_o) else $error("request executed during memory clear");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt released without reset");

  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_adv && status != ST_OK) |=> (halted_q && w_valid_q))
    else $error("error did not halt");

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_DEPTH)) else $error("stack pointer beyond depth");

endmodule

FILE: rtl/core/small_stack_isa_executor_top.sv
// ----------------------------------------------------------------------------
// small_stack_isa_executor_top
// Executes one 32-bit stack ISA instruction per request.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_ready_o with in_req_i (instruction word and
// end-of-program flag). Output channel: out_valid_o / out_ready_i with
// out_rsp_o (status, r0..r3 after the instruction, echoed end flag).
// Each request yields exactly one response, in order.
// An accepted request is written into the queue and executed straight out of
// the queue into the response register.
// Throughput: one request per cycle unless out_ready_i stalls; a pop or ldr
// result is forwarded from the registered memory read data into the next request.
// Reset: registers, stack pointer and halt flag clear at once; the data
// memory is then swept to zero, one word per cycle through all 2048 words,
// during which in_ready_o stays low.
// A stalled receiver holds the response; up to two further requests wait in
// the queue before in_ready_o drops.
// After any error the block halts: later requests return status halted with
// the registers unchanged until reset.
// ----------------------------------------------------------------------------
module small_stack_isa_executor_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ssie_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssie_pkg::rsp_t out_rsp_o
);
  import ssie_pkg::*;

  logic clearing;
  logic q_full;
  logic q_push;
  logic q_valid;
  logic q_pop;
  dec_t q_in;
  dec_t q_out;

  ssie_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .clearing_i (clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_dec_o    (q_in)
  );

  ssie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .dec_i   (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .dec_o   (q_out)
  );

  ssie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .x_valid_i   (q_valid),
    .x_dec_i     (q_out),
    .x_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the small stack ISA executor.
// A short table of directed instructions runs first. About a thousand random
// instructions follow; they keep the stack and memory addresses legal, so the
// run goes deep before one randomly chosen fault halts the block. Requests
// sent to the halted block close the run. An instruction model inside the
// bench predicts every response, and the responses are compared in order.
// ----------------------------------------------------------------------------
module tb;
  import ssie_pkg::*;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } vector_t;

  localparam int unsigned RANDOM_ITEMS = 1050;
  localparam int unsigned HALTED_ITEMS = 20;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic [4:0] NOP_OPS [8] = '{OPC_NOP2, OPC_NOP3, OPC_NOP15, OPC_NOP16,
                                         OPC_NOP17, OPC_NOP18, OPC_NOP20, OPC_NOP21};
  localparam logic [4:0] REG_OPS [10] = '{OPC_MOVI, OPC_MOVR, OPC_PUSH, OPC_ADDI,
                                          OPC_ADDR, OPC_POP, OPC_MULI, OPC_MULR,
                                          OPC_LDR, OPC_STR};

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  logic [31:0] arch_regs [NUM_REGS]     = '{default: '0};
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] data_mem  [MEMORY_WORDS] = '{default: '0};
  int unsigned stack_ptr = 0;
  bit          halted    = 1'b0;
  bit          mem_next  = 1'b0;

  rsp_t        pending_results [$];
  vector_t     directed [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left   = 0;
  bit          hold_on      = 1'b0;

  small_stack_isa_executor_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic opkind_e kind_of(input logic [4:0] opc);
    case (opc)
      OPC_MOVI: return K_MOVI;
      OPC_MOVR: return K_MOVR;
      OPC_PUSH: return K_PUSH;
      OPC_ADDI: return K_ADDI;
      OPC_ADDR: return K_ADDR;
      OPC_POP:  return K_POP;
      OPC_MULI: return K_MULI;
      OPC_MULR: return K_MULR;
      OPC_LDR:  return K_LDR;
      OPC_STR:  return K_STR;
      OPC_NOP2, OPC_NOP3, OPC_NOP15, OPC_NOP16,
      OPC_NOP17, OPC_NOP18, OPC_NOP20, OPC_NOP21: return K_NOP;
      default: return K_ILLEGAL;
    endcase
  endfunction

  function automatic bit reads_src(input opkind_e k);
    return k inside {K_MOVR, K_ADDR, K_MULR, K_LDR, K_STR};
  endfunction

  function automatic logic [31:0] enc_imm(input logic [4:0] opc, input logic [2:0] d,
                                          input logic [23:0] imm);
    return {opc, d, imm};
  endfunction

  function automatic logic [31:0] enc_reg(input logic [4:0] opc, input logic [2:0] d,
                                          input logic [2:0] s, input logic [20:0] pad);
    return {opc, d, s, pad};
  endfunction

  // address an ldr or str would use next, r2 already advanced
  function automatic logic [31:0] addr_seen(input logic [1:0] r);
    return (r == PC_REG) ? arch_regs[r] + PC_STEP : arch_regs[r];
  endfunction

  function automatic logic [23:0] pick_imm();
    case ($urandom_range(0, 7))
      0: return 24'h0;
      1: return 24'hFF_FFFF;
      2: return 24'($urandom_range(0, 15));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic rsp_t execute_instr(input req_t rq);
    rsp_t        rs;
    status_e     st;
    opkind_e     k;
    logic [2:0]  d;
    logic [2:0]  s;
    logic [23:0] imm;
    logic [31:0] src_val;
    k   = kind_of(rq.instruction[31:27]);
    d   = rq.instruction[26:24];
    s   = rq.instruction[23:21];
    imm = rq.instruction[23:0];
    st  = ST_OK;
    if (halted) begin
      st = ST_HALTED;
    end else begin
      arch_regs[PC_REG] = arch_regs[PC_REG] + PC_STEP;
      src_val = arch_regs[s[1:0]];
      if (k == K_ILLEGAL) begin
        st = ST_OPCODE;
      end else if (k != K_NOP && d[2]) begin
        st = ST_REGISTER;
      end else if (reads_src(k) && s[2]) begin
        st = ST_REGISTER;
      end else begin
        case (k)
          K_MOVI: arch_regs[d[1:0]] = {8'h00, imm};
          K_MOVR: arch_regs[d[1:0]] = src_val;
          K_ADDI: arch_regs[d[1:0]] = arch_regs[d[1:0]] + {8'h00, imm};
          K_ADDR: arch_regs[d[1:0]] = arch_regs[d[1:0]] + src_val;
          K_MULI: arch_regs[d[1:0]] = arch_regs[d[1:0]] * {8'h00, imm};
          K_MULR: arch_regs[d[1:0]] = arch_regs[d[1:0]] * src_val;
          K_PUSH: begin
            if (stack_ptr >= STACK_DEPTH) begin
              st = ST_OVERFLOW;
            end else begin
              stack_mem[stack_ptr] = arch_regs[d[1:0]];
              stack_ptr++;
            end
          end
          K_POP: begin
            if (stack_ptr == 0) begin
              st = ST_UNDERFLOW;
            end else begin
              stack_ptr--;
              arch_regs[d[1:0]] = stack_mem[stack_ptr];
            end
          end
          K_LDR: begin
            if (src_val >= MEMORY_WORDS) st = ST_RANGE;
            else arch_regs[d[1:0]] = data_mem[src_val[MA_W-1:0]];
          end
          K_STR: begin
            if (src_val >= MEMORY_WORDS) st = ST_RANGE;
            else data_mem[src_val[MA_W-1:0]] = arch_regs[d[1:0]];
          end
          default: ;
        endcase
      end
      if (st != ST_OK) halted = 1'b1;
    end
    rs.status       = st;
    rs.reg0         = arch_regs[0];
    rs.reg1         = arch_regs[1];
    rs.reg2         = arch_regs[2];
    rs.reg3         = arch_regs[3];
    rs.program_done = rq.end_of_program;
    return rs;
  endfunction

  function automatic req_t next_random();
    req_t        rq;
    logic [1:0]  d;
    logic [1:0]  s;
    logic [1:0]  a;
    int unsigned w;
    bit          found;
    d     = 2'($urandom_range(0, 3));
    s     = 2'($urandom_range(0, 3));
    found = 1'b0;
    rq.end_of_program = ($urandom_range(0, 15) == 0);
    w = mem_next ? 80 : $urandom_range(0, 99);
    mem_next = 1'b0;
    if (w < 8) begin
      rq.instruction = {NOP_OPS[$urandom_range(0, 7)], 27'($urandom)};
    end else if (w < 18) begin
      rq.instruction = enc_imm(OPC_MOVI, {1'b0, d}, pick_imm());
    end else if (w < 26) begin
      rq.instruction = enc_reg(OPC_MOVR, {1'b0, d}, {1'b0, s}, 21'($urandom));
    end else if (w < 36) begin
      rq.instruction = enc_imm(OPC_ADDI, {1'b0, d}, pick_imm());
    end else if (w < 44) begin
      rq.instruction = enc_reg(OPC_ADDR, {1'b0, d}, {1'b0, s}, 21'($urandom));
    end else if (w < 52) begin
      rq.instruction = enc_imm(OPC_MULI, {1'b0, d}, pick_imm());
    end else if (w < 58) begin
      rq.instruction = enc_reg(OPC_MULR, {1'b0, d}, {1'b0, s}, 21'($urandom));
    end else if (w < 70 || stack_ptr == 0) begin
      rq.instruction = enc_imm(OPC_PUSH, {1'b0, d}, 24'($urandom));
    end else if (w < 80) begin
      rq.instruction = enc_imm(OPC_POP, {1'b0, d}, 24'($urandom));
    end else begin
      a = 2'($urandom_range(0, 3));
      for (int i = 0; i < NUM_REGS; i++) begin
        if (!found && addr_seen(2'(a + i)) < MEMORY_WORDS) begin
          found = 1'b1;
          s     = 2'(a + i);
        end
      end
      if (found) begin
        rq.instruction = enc_reg(($urandom_range(0, 1) != 0) ? OPC_LDR : OPC_STR,
                                 {1'b0, d}, {1'b0, s}, 21'($urandom));
      end else begin
        a = ($urandom_range(0, 1) != 0) ? 2'd0 : 2'd3;
        rq.instruction = enc_imm(OPC_MOVI, {1'b0, a},
                                 ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 31)) :
                                 24'($urandom_range(0, MEMORY_WORDS - 1)));
        mem_next = 1'b1;
      end
    end
    return rq;
  endfunction

  task automatic add_row(input logic [31:0] ins, input logic eop, input bit typed,
                         input rsp_t want);
    vector_t v;
    v.req.instruction    = ins;
    v.req.end_of_program = eop;
    v.typed              = typed;
    v.want               = want;
    directed.push_back(v);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic issue(input req_t rq, input bit typed, input rsp_t want);
    rsp_t model;
    if (burst_left == 0 && !hold_on) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 120 : $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= rq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    model = execute_instr(rq);
    pending_results.push_back(typed ? want : model);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, field, want, got);
    end
  endtask

  initial begin
    req_t       rq;
    status_e    fault;
    logic [4:0] opc;
    logic [2:0] d;
    logic [2:0] s;
    logic [1:0] a;

    add_row(enc_imm(OPC_NOP2, 3'd0, 24'h0), 1'b0, 1'b1,
            rsp_t'{ST_OK, 32'h0, 32'h0, 32'd4, 32'h0, 1'b0});
    add_row(enc_imm(OPC_MOVI, 3'd0, 24'hFF_FFFF), 1'b0, 1'b1,
            rsp_t'{ST_OK, 32'h00FF_FFFF, 32'h0, 32'd8, 32'h0, 1'b0});
    add_row(enc_imm(OPC_MOVI, 3'd1, 24'hE0_0000), 1'b0, 1'b1,
            rsp_t'{ST_OK, 32'h00FF_FFFF, 32'h00E0_0000, 32'd12, 32'h0, 1'b0});
    add_row(enc_imm(OPC_NOP21, 3'd7, 24'hFF_FFFF), 1'b1, 1'b1,
            rsp_t'{ST_OK, 32'h00FF_FFFF, 32'h00E0_0000, 32'd16, 32'h0, 1'b1});
    add_row(enc_imm(OPC_MULI, 3'd0, 24'hFF_FFFF), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_MULR, 3'd0, 3'd0, 21'h0), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_ADDI, 3'd3, 24'hFF_FFFF), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_ADDR, 3'd3, 3'd0, 21'h0), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_MOVR, 3'd1, 3'd2, 21'h1F_FFFF), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_PUSH, 3'd0, 24'h0), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_PUSH, 3'd3, 24'hFF_FFFF), 1'b1, 1'b0, '0);
    add_row(enc_imm(OPC_POP, 3'd1, 24'h0), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_POP, 3'd0, 24'h0), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_MOVI, 3'd3, 24'(MEMORY_WORDS - 1)), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_STR, 3'd1, 3'd3, 21'h0), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_LDR, 3'd0, 3'd3, 21'h0), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_MOVI, 3'd3, 24'h0), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_STR, 3'd0, 3'd3, 21'h0), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_LDR, 3'd1, 3'd3, 21'h0), 1'b0, 1'b0, '0);
    add_row(enc_reg(OPC_LDR, 3'd0, 3'd2, 21'h0), 1'b1, 1'b0, '0);
    add_row(enc_imm(OPC_NOP3, 3'd4, 24'h0), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_NOP15, 3'd5, 24'h5A_5A5A), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_NOP16, 3'd6, 24'hA5_A5A5), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_NOP17, 3'd0, 24'hFF_FFFF), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_NOP18, 3'd3, 24'h0), 1'b0, 1'b0, '0);
    add_row(enc_imm(OPC_NOP20, 3'd7, 24'h12_3456), 1'b1, 1'b0, '0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) issue(directed[i].req, directed[i].typed, directed[i].want);
    repeat (RANDOM_ITEMS) issue(next_random(), 1'b0, '0);

    fault = status_e'($urandom_range(ST_UNDERFLOW, ST_REGISTER));
    rq.end_of_program = 1'b0;
    case (fault)
      ST_UNDERFLOW: begin
        while (!halted) begin
          rq.instruction = enc_imm(OPC_POP, 3'($urandom_range(0, 3)), 24'($urandom));
          issue(rq, 1'b0, '0);
        end
      end
      ST_RANGE: begin
        a = ($urandom_range(0, 1) != 0) ? 2'd1 : 2'd3;
        rq.instruction = enc_imm(OPC_MOVI, {1'b0, a},
                                 ($urandom_range(0, 1) != 0) ? 24'(MEMORY_WORDS) :
                                 24'($urandom_range(MEMORY_WORDS, 24'hFF_FFFF)));
        issue(rq, 1'b0, '0);
        rq.instruction = enc_reg(($urandom_range(0, 1) != 0) ? OPC_LDR : OPC_STR,
                                 3'($urandom_range(0, 3)), {1'b0, a}, 21'($urandom));
        issue(rq, 1'b0, '0);
      end
      ST_OPCODE: begin
        do opc = 5'($urandom); while (kind_of(opc) != K_ILLEGAL);
        rq.instruction = {opc, 27'($urandom)};
        issue(rq, 1'b0, '0);
      end
      default: begin
        opc = REG_OPS[$urandom_range(0, 9)];
        if (reads_src(kind_of(opc)) && $urandom_range(0, 1) != 0) begin
          d = 3'($urandom);
          s = 3'($urandom_range(4, 7));
        end else begin
          d = 3'($urandom_range(4, 7));
          s = 3'($urandom);
        end
        rq.instruction = enc_reg(opc, d, s, 21'($urandom));
        issue(rq, 1'b0, '0);
      end
    endcase

    repeat (HALTED_ITEMS) begin
      rq.instruction    = $urandom;
      rq.end_of_program = 1'($urandom_range(0, 1));
      issue(rq, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    int unsigned pattern;
    bit          hold_done;
    stall_left = 0;
    pattern    = 0;
    hold_done  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_on   = 1'b1;
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_on = 1'b0;
      end
      if (stall_left == 0) begin
        pattern    = $urandom_range(0, 2);
        stall_left = $urandom_range(8, 64);
      end
      stall_left--;
      case (pattern)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 1) != 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: response with no request outstanding, expected none actual %h",
                 $time, out_rsp_o);
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_rsp_o.status);
        check_field("reg0", want.reg0, out_rsp_o.reg0);
        check_field("reg1", want.reg1, out_rsp_o.reg1);
        check_field("reg2", want.reg2, out_rsp_o.reg2);
        check_field("reg3", want.reg3, out_rsp_o.reg3);
        check_field("program_done", want.program_done, out_rsp_o.program_done);
      end
    end
  end

endmodule

FILE: small_stack_isa_executor_top.f
rtl/core/ssie_pkg.sv
rtl/core/ssie_front.sv
rtl/core/ssie_queue.sv
rtl/core/ssie_back.sv
rtl/core/small_stack_isa_executor_top.sv
sim/tb.sv
